// ===== rtl/twsm_pkg.sv =====
// Shared constants, state type and tap weight function of the triangular window smoother.
package twsm_pkg;

    localparam int CFG_BITS  = 4;
    localparam int H_BITS    = 3;
    localparam int WT_BITS   = 4;
    localparam int DIV_BITS  = 7;
    localparam int GROW_BITS = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_EMIT
    } t_state;

    function automatic logic [WT_BITS-1:0] tap_weight(input logic [H_BITS-1:0] h, input int idx);
        int d;
        d = idx - int'(h);
        if (d < 0) begin
            d = -d;
        end
        if (d > int'(h)) begin
            return '0;
        end
        return WT_BITS'(int'(h) + 1 - d);
    endfunction

endpackage

// ===== rtl/twsm_cell.sv =====
// One history cell: holds a sample, shifts it on, and adds its weighted tap to the running sum.
module twsm_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int SUM_BITS    = 23
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_shift,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic [twsm_pkg::WT_BITS-1:0]        i_weight,
    input  logic signed [SUM_BITS-1:0]          i_psum,
    output logic signed [SAMPLE_BITS-1:0]       o_sample,
    output logic signed [SUM_BITS-1:0]          o_psum
);

    localparam int PROD_BITS = SAMPLE_BITS + twsm_pkg::WT_BITS + 1;

    logic signed [SAMPLE_BITS-1:0]   r_sample;
    logic signed [SUM_BITS-1:0]      r_psum;
    logic signed [SUM_BITS-1:0]      n_psum;
    logic signed [twsm_pkg::WT_BITS:0] w_wt;
    logic signed [PROD_BITS-1:0]     w_prod;

    assign w_wt   = $signed({1'b0, i_weight});
    assign w_prod = w_wt * r_sample;
    assign n_psum = i_psum + SUM_BITS'(w_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        r_psum <= n_psum;
    end

    assign o_sample = r_sample;
    assign o_psum   = r_psum;

endmodule

// ===== rtl/twsm_div.sv =====
// Restoring divider, one quotient bit a cycle, for the window sum by the squared centre weight.
module twsm_div #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [SAMPLE_BITS+twsm_pkg::GROW_BITS-1:0] i_dividend,
    input  logic [twsm_pkg::DIV_BITS-1:0]        i_divisor,
    output logic                                 o_done,
    output logic signed [SAMPLE_BITS-1:0]        o_quotient
);

    localparam int SUM_BITS = SAMPLE_BITS + twsm_pkg::GROW_BITS;
    localparam int DB       = twsm_pkg::DIV_BITS;
    localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_neg;
    logic [DB-1:0]          r_rem;
    logic [DB-1:0]          r_div;
    logic [SAMPLE_BITS-1:0] r_q;
    logic [SUM_BITS-1:0]    w_mag;
    logic [DB:0]            w_trial;
    logic [DB:0]            w_diff;
    logic                   w_ge;
    logic [SAMPLE_BITS-1:0] w_q_neg;

    assign w_mag   = i_dividend[SUM_BITS-1] ? SUM_BITS'(-i_dividend) : SUM_BITS'(i_dividend);
    assign w_trial = {r_rem, r_q[SAMPLE_BITS-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_BITS'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(SAMPLE_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_BITS-1];
            r_div <= i_divisor;
            r_rem <= w_mag[SUM_BITS-1:SAMPLE_BITS];
            r_q   <= w_mag[SAMPLE_BITS-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DB-1:0] : w_trial[DB-1:0];
            r_q   <= {r_q[SAMPLE_BITS-2:0], w_ge};
        end
    end

    assign w_q_neg    = -r_q;
    assign o_done     = r_done;
    assign o_quotient = $signed(r_neg ? w_q_neg : r_q);

endmodule

// ===== rtl/triangular_window_smoother.sv =====
// Top level of the triangular window smoother: cell chain, divider, result sequencer.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+----------------------------------
//  input    | in        | i_in_valid / o_in_stall    | i_sample, i_frame_end
//  output   | out       | o_out_valid / i_out_stall  | o_smoothed, o_at_edge, o_final_out
//  config   | in        | i_cfg_valid / o_cfg_ready  | i_cfg_window_size
//
//  An averaged word is taken, its sum runs down the cell chain in ST_SUM and launches the
//  divider, and the bit-serial divider in ST_DIV yields the quotient; then each result word
//  is emitted in ST_EMIT. A word giving only edge zeros goes straight to ST_EMIT; one giving
//  none leaves the block idle.
//  Reset is synchronous: window size 3, history and frame position cleared.
//  Output stall holds the result register; input stall is high until the item is done.
module triangular_window_smoother #(
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_WINDOW  = 15
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        i_sample,
    input  logic                                 i_frame_end,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_smoothed,
    output logic                                 o_at_edge,
    output logic                                 o_final_out,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [twsm_pkg::CFG_BITS-1:0]        i_cfg_window_size
);

    localparam int SUM_BITS  = SAMPLE_BITS + twsm_pkg::GROW_BITS;
    localparam int HB        = twsm_pkg::H_BITS;
    localparam int POS_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int TAP_BITS  = $clog2(MAX_WINDOW + 1);
    localparam int LEFT_BITS = HB + 1;
    localparam int CW        = ((POS_BITS > HB) ? POS_BITS : HB) + 2;
    localparam int MAX_ODD   = (MAX_WINDOW % 2 == 1) ? MAX_WINDOW : MAX_WINDOW - 1;

    twsm_pkg::t_state r_state, n_state;

    logic [twsm_pkg::CFG_BITS-1:0] r_window;
    logic [POS_BITS-1:0]           r_pos, n_pos;
    logic [HB-1:0]                 r_h, n_h;
    logic [HB:0]                   r_cnt, n_cnt;
    logic [LEFT_BITS-1:0]          r_left, n_left;
    logic                          r_last, n_last;
    logic                          r_edge, n_edge;
    logic signed [SAMPLE_BITS-1:0] r_result, n_result;
    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_smoothed, n_smoothed;
    logic                          r_at_edge, n_at_edge;
    logic                          r_final_out, n_final_out;

    logic [HB-1:0]                 w_h;
    logic                          w_in_accept;
    logic                          w_slot_free;
    logic                          w_has_main;
    logic                          w_is_avg;
    logic [HB-1:0]                 w_flush;
    logic                          w_div_start;
    logic                          w_div_done;
    logic signed [SAMPLE_BITS-1:0] w_quot;
    logic [HB:0]                   w_hp1;
    logic [2*HB+1:0]               w_sq;
    logic [TAP_BITS-1:0]           w_tap_idx;

    logic signed [SAMPLE_BITS-1:0] w_sample [MAX_WINDOW+1];
    logic signed [SUM_BITS-1:0]    w_psum   [MAX_WINDOW+1];
    logic [twsm_pkg::WT_BITS-1:0]  w_weight [MAX_WINDOW];

    always_comb begin
        int wv;
        wv = int'(r_window);
        if (wv % 2 == 0) begin
            wv = (wv == 0) ? 1 : wv - 1;
        end
        if (wv > MAX_WINDOW) begin
            wv = MAX_ODD;
        end
        w_h = HB'(wv >> 1);
    end

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_has_main  = CW'(r_pos) >= CW'(w_h);
    assign w_is_avg    = CW'(r_pos) >= (CW'(w_h) << 1);
    assign w_flush     = (CW'(r_pos) + CW'(1) < CW'(w_h)) ? HB'(CW'(r_pos) + CW'(1)) : w_h;

    assign w_sample[0] = i_sample;
    assign w_psum[0]   = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            assign w_weight[gi] = twsm_pkg::tap_weight(r_h, gi);
            twsm_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .SUM_BITS    (SUM_BITS)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_shift  (w_in_accept),
                .i_sample (w_sample[gi]),
                .i_weight (w_weight[gi]),
                .i_psum   (w_psum[gi]),
                .o_sample (w_sample[gi+1]),
                .o_psum   (w_psum[gi+1])
            );
        end
    endgenerate

    assign w_tap_idx = TAP_BITS'({r_h, 1'b1});
    assign w_hp1     = {1'b0, r_h} + 1'b1;
    assign w_sq      = w_hp1 * w_hp1;

    twsm_div #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_psum[w_tap_idx]),
        .i_divisor  (w_sq[twsm_pkg::DIV_BITS-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_h         = r_h;
        n_cnt       = r_cnt;
        n_left      = r_left;
        n_last      = r_last;
        n_edge      = r_edge;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_smoothed  = r_smoothed;
        n_at_edge   = r_at_edge;
        n_final_out = r_final_out;
        w_div_start = 1'b0;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            twsm_pkg::ST_IDLE: begin
                if (w_in_accept) begin
                    n_h      = w_h;
                    n_cnt    = {w_h, 1'b1};
                    n_left   = LEFT_BITS'(w_has_main) + LEFT_BITS'(i_frame_end ? w_flush : '0);
                    n_last   = i_frame_end;
                    n_edge   = !w_is_avg;
                    n_result = '0;
                    if (i_frame_end) begin
                        n_pos = '0;
                    end else if (r_pos < POS_BITS'(MAX_WINDOW)) begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (w_is_avg) begin
                        n_state = twsm_pkg::ST_SUM;
                    end else if (n_left != '0) begin
                        n_state = twsm_pkg::ST_EMIT;
                    end
                end
            end
            twsm_pkg::ST_SUM: begin
                if (r_cnt == '0) begin
                    w_div_start = 1'b1;
                    n_state     = twsm_pkg::ST_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            twsm_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_result = w_quot;
                    n_state  = twsm_pkg::ST_EMIT;
                end
            end
            twsm_pkg::ST_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_smoothed  = r_result;
                    n_at_edge   = r_edge;
                    n_final_out = r_last && (r_left == LEFT_BITS'(1));
                    n_left      = r_left - 1'b1;
                    n_result    = '0;
                    n_edge      = 1'b1;
                    if (r_left == LEFT_BITS'(1)) begin
                        n_state = twsm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = twsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= twsm_pkg::ST_IDLE;
            r_window    <= twsm_pkg::CFG_BITS'(3);
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_left      <= '0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_left      <= n_left;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_cfg_window_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h         <= n_h;
        r_last      <= n_last;
        r_edge      <= n_edge;
        r_result    <= n_result;
        r_smoothed  <= n_smoothed;
        r_at_edge   <= n_at_edge;
        r_final_out <= n_final_out;
    end

    assign o_in_stall  = (r_state != twsm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_smoothed  = r_smoothed;
    assign o_at_edge   = r_at_edge;
    assign o_final_out = r_final_out;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == twsm_pkg::ST_DIV))
        else $error("divider finished outside the divide phase");

    a_left_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twsm_pkg::ST_EMIT) |-> (r_left != '0) && (r_left <= ({1'b0, r_h} + 1'b1)))
        else $error("result count out of range");

    a_sum_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == twsm_pkg::ST_SUM) |-> (r_cnt <= {r_h, 1'b1}))
        else $error("chain count beyond window length");

    a_edge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_at_edge) |-> (o_smoothed == '0))
        else $error("edge word carries a non-zero value");

endmodule
